// File: src/banked_rom_mapper_defines.svh
// ----------------------------------------------------------------------------
// Banked ROM mapper assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BANKED_ROM_MAPPER_DEFINES_SVH
`define BANKED_ROM_MAPPER_DEFINES_SVH

`ifndef SYNTH
`define BRM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BRM_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BRM_ASSERT(label, clk, rst_n, prop, msg)
`define BRM_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// File: src/brm_pkg.sv
// ----------------------------------------------------------------------------
// Banked ROM mapper package
// Shared constants, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package brm_pkg;

	localparam int MEM_PAGES        = 256;
	localparam int PAGE_BYTES       = 4096;
	localparam int BANK_WINDOW_BASE = 24568;

	localparam int PAGE_W     = $clog2(MEM_PAGES);
	localparam int OFS_LO_W   = $clog2(PAGE_BYTES);
	localparam int MEM_AW     = PAGE_W + OFS_LO_W;
	localparam int MEM_DEPTH  = MEM_PAGES * PAGE_BYTES;

	localparam int S_TDATA_W  = 48;
	localparam int S_TUSER_W  = 2;
	localparam int M_TDATA_W  = 8;
	localparam int M_TUSER_W  = 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [1:0] {
		OP_BUS_READ    = 2'd0,
		OP_BUS_WRITE   = 2'd1,
		OP_IMAGE_READ  = 2'd2,
		OP_IMAGE_WRITE = 2'd3
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BANKING_ENABLE = 2'd0,
		CFG_LOAD_ADDRESS   = 2'd1,
		CFG_IMAGE_PAGES    = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic clear_wr;
		logic accept;
		logic issue;
		logic load_out;
	} brm_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic out_free;
		logic out_valid;
	} brm_sts_t;

endpackage

`default_nettype wire

// File: src/brm_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module brm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: src/brm_datapath.sv
// ----------------------------------------------------------------------------
// Banked ROM mapper datapath
// Configuration and bank registers, address mapping, image RAM and output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module brm_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [brm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [brm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic [brm_pkg::S_TDATA_W-1:0]   s_tdata,
	input  wire logic [brm_pkg::S_TUSER_W-1:0]   s_tuser,
	input  wire logic                            m_tready,
	output logic      [brm_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic      [brm_pkg::M_TUSER_W-1:0]   m_tuser,
	input  wire brm_pkg::brm_cmd_t               cmd,
	output brm_pkg::brm_sts_t                    sts
);

	import brm_pkg::*;

	logic        banking_q;
	logic [15:0] load_addr_q;
	logic [8:0]  pages_q;
	logic [7:0]  bank_q [8];

	logic        chip_select;
	logic [15:0] bus_addr;
	logic [19:0] image_addr;
	logic [7:0]  wr_data;
	logic        is_write;

	logic [2:0]  bank_sel;
	logic [7:0]  bank_rd;
	logic        bank_we;
	logic        hit;
	logic        in_range;
	logic [19:0] ofs;
	logic [15:0] flat_ofs;
	logic        is_mem_d;
	logic        we_d;
	logic        re_d;
	logic        driven_d;
	logic [7:0]  const_d;

	logic              is_mem_s1;
	logic              we_s1;
	logic              re_s1;
	logic              driven_s1;
	logic [7:0]        const_s1;
	logic [MEM_AW-1:0] addr_s1;
	logic [7:0]        wdata_s1;

	logic [MEM_AW-1:0] clr_cnt_q;
	logic              ram_we;
	logic              ram_re;
	logic [MEM_AW-1:0] ram_addr;
	logic [7:0]        ram_wdata;
	logic [7:0]        ram_rdata;

	logic       out_valid_q;
	logic [7:0] out_data_q;
	logic       out_driven_q;

	assign chip_select = s_tdata[0];
	assign bus_addr    = s_tdata[16:1];
	assign image_addr  = s_tdata[36:17];
	assign wr_data     = s_tdata[44:37];
	assign is_write    = s_tuser[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			banking_q   <= 1'b0;
			load_addr_q <= 16'h8000;
			pages_q     <= 9'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BANKING_ENABLE: banking_q   <= cfg_data[0];
				CFG_LOAD_ADDRESS:   load_addr_q <= cfg_data[15:0];
				CFG_IMAGE_PAGES:    pages_q     <= cfg_data[8:0];
				default:            ;
			endcase
		end
	end

	// single bank read port: window register or slot register
	always_comb begin
		if (bus_addr[15:3] == 13'(BANK_WINDOW_BASE >> 3)) begin
			bank_sel = bus_addr[2:0];
		end else begin
			bank_sel = bus_addr[14:12];
		end
	end

	assign bank_rd  = bank_q[bank_sel];
	assign flat_ofs = bus_addr - load_addr_q;

	always_comb begin
		hit     = 1'b0;
		bank_we = 1'b0;
		ofs     = image_addr;
		if (s_tuser[1]) begin
			hit = 1'b1;
		end else if (chip_select) begin
			if (banking_q) begin
				if (bus_addr[15:3] == 13'(BANK_WINDOW_BASE >> 3)) begin
					bank_we = is_write;
				end else if (bus_addr[15]) begin
					hit = 1'b1;
					ofs = {bank_rd, bus_addr[11:0]};
				end
			end else if (bus_addr >= load_addr_q) begin
				hit = 1'b1;
				ofs = {4'd0, flat_ofs};
			end
		end
	end

	assign in_range = ({1'b0, ofs[19:12]} < pages_q) && ({1'b0, ofs[19:12]} < 9'(MEM_PAGES));

	always_comb begin
		is_mem_d = 1'b0;
		we_d     = 1'b0;
		re_d     = 1'b0;
		driven_d = 1'b0;
		const_d  = 8'h00;
		if (hit) begin
			if (in_range) begin
				we_d     = is_write;
				re_d     = !is_write;
				is_mem_d = !is_write;
				driven_d = !is_write;
			end else if (!is_write) begin
				const_d  = 8'hFF;
				driven_d = 1'b1;
			end
		end else if (!s_tuser[1] && chip_select && banking_q && !is_write &&
				bus_addr[15:3] == 13'(BANK_WINDOW_BASE >> 3)) begin
			const_d  = bank_rd;
			driven_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				bank_q[i] <= 8'h00;
			end
		end else if (cmd.accept && bank_we) begin
			bank_q[bus_addr[2:0]] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			is_mem_s1 <= is_mem_d;
			we_s1     <= we_d;
			re_s1     <= re_d;
			driven_s1 <= driven_d;
			const_s1  <= const_d;
			addr_s1   <= ofs[MEM_AW-1:0];
			wdata_s1  <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear_wr && !sts.clear_last) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	assign ram_we    = cmd.clear_wr || (cmd.issue && we_s1);
	assign ram_re    = cmd.issue && re_s1;
	assign ram_addr  = cmd.clear_wr ? clr_cnt_q : addr_s1;
	assign ram_wdata = cmd.clear_wr ? 8'hFF : wdata_s1;

	brm_ram #(
		.WIDTH (8),
		.DEPTH (MEM_DEPTH)
	) u_image_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q   <= is_mem_s1 ? ram_rdata : const_s1;
			out_driven_q <= driven_s1;
		end
	end

	assign m_tdata        = out_data_q;
	assign m_tuser        = out_driven_q;
	assign sts.clear_last = (clr_cnt_q == MEM_AW'(MEM_DEPTH - 1));
	assign sts.out_free   = !out_valid_q || m_tready;
	assign sts.out_valid  = out_valid_q;

endmodule

`default_nettype wire

// File: src/brm_ctrl.sv
// ----------------------------------------------------------------------------
// Banked ROM mapper controller
// Sequences the clearing pass, transaction acceptance, RAM access and response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "banked_rom_mapper_defines.svh"

module brm_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire brm_pkg::brm_sts_t sts,
	output brm_pkg::brm_cmd_t      cmd
);

	import brm_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_ACCESS = 4'b0100,
		ST_RESP   = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_ACCESS;
				end
			end
			ST_ACCESS: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready     = (state_q == ST_IDLE);
	assign cmd.clear_wr = (state_q == ST_CLEAR);
	assign cmd.accept   = (state_q == ST_IDLE) && s_tvalid;
	assign cmd.issue    = (state_q == ST_ACCESS);
	assign cmd.load_out = (state_q == ST_RESP) && sts.out_free;

	`BRM_ASSERT(a_accept_to_access, clk, arst_n, cmd.accept |=> (state_q == ST_ACCESS), "accepted transaction did not reach RAM access")
	`BRM_ASSERT(a_access_to_resp, clk, arst_n, cmd.issue |=> (state_q == ST_RESP), "RAM access not followed by response")
	`BRM_ASSERT(a_no_overwrite, clk, arst_n, cmd.load_out |-> (!sts.out_valid || sts.out_free), "output register overwritten while stalled")
	`BRM_ASSERT(a_clear_holds, clk, arst_n, (cmd.clear_wr && !sts.clear_last) |=> cmd.clear_wr, "clearing pass left early")
	`BRM_ASSERT_ALWAYS(a_no_accept_in_reset, clk, !arst_n |-> !cmd.accept, "transaction accepted during reset")

endmodule

`default_nettype wire

// File: src/banked_rom_mapper.sv
// ----------------------------------------------------------------------------
// Banked ROM mapper
// Music-image byte memory behind a 16-bit CPU bus with bank switching.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one access per transaction: opcode in s_tuser, chip select,
//   bus address, image address and write byte in s_tdata. m_* returns one
//   result per access: the read byte in m_tdata and the driven flag in m_tuser.
//   Writes and ignored accesses return a zero byte with the flag clear.
//   Configuration (banking enable, load address, image pages) is written
//   through cfg_we/cfg_index/cfg_data while no access is in flight.
// Access sequence:
//   The accepting edge registers the mapped access; the image RAM is then read
//   and the output register is loaded, which raises m_tvalid. The single RAM port
//   is used once per access, and the next access is accepted only after this
//   one has loaded its result into the output register.
// Reset:
//   After arst_n releases, a clearing pass writes 0xFF to all 1048576 image
//   bytes, one per cycle; s_tready stays low for those cycles. Bank registers
//   reset to zero.
// Stall:
//   A stalled m_tready holds the result in the output register; the next
//   access may be accepted meanwhile but waits before its own result is loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module banked_rom_mapper (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [brm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [brm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// chip_select, bus_address[15:0], image_address[19:0], write_data[7:0], pad
	input  wire logic [brm_pkg::S_TDATA_W-1:0]   s_tdata,
	// opcode[1:0]
	input  wire logic [brm_pkg::S_TUSER_W-1:0]   s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// read_data[7:0]
	output logic      [brm_pkg::M_TDATA_W-1:0]   m_tdata,
	// data_driven
	output logic      [brm_pkg::M_TUSER_W-1:0]   m_tuser
);

	import brm_pkg::*;

	brm_cmd_t cmd;
	brm_sts_t sts;

	brm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	brm_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.sts       (sts)
	);

	assign m_tvalid = sts.out_valid;

endmodule

`default_nettype wire

// File: dv/tb_banked_rom_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Banked ROM mapper testbench
// Drives bus and image accesses in random bursts against a shadow of the bank
// registers and the image memory, under flat and bank-switched mappings,
// and checks every returned byte and driven flag in order.
// ----------------------------------------------------------------------------

module tb_banked_rom_mapper;

	import brm_pkg::*;

	typedef struct {
		opcode_t     op;
		logic        cs;
		logic [15:0] bus_addr;
		logic [19:0] img_addr;
		logic [7:0]  wdata;
	} access_t;

	typedef struct {
		logic [7:0] rdata;
		logic       driven;
	} rom_reply_t;

	localparam logic [15:0] WINDOW_BASE = 16'(BANK_WINDOW_BASE);
	localparam int          RANDOM_PER_SETTING = 200;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic [S_TUSER_W-1:0]  s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [M_TUSER_W-1:0]  m_tuser;

	// shadow of the mapping settings and the block's storage
	logic        map_banked = 1'b0;
	logic [15:0] flat_base = 16'h8000;
	logic [8:0]  image_pages_cfg = 9'd256;
	logic [7:0]  bank_shadow [8];
	logic [7:0]  image_shadow [int unsigned];

	access_t    access_q [$];
	rom_reply_t reply_q [$];
	access_t    cur_access;

	logic took = 1'b0;
	int   burst_left = 0;
	int   gap_left = 0;
	int   stall_mode = 0;
	int   stall_cnt = 0;
	int   errors = 0;
	int   n_settings = 0;
	int   n_op [4] = '{0, 0, 0, 0};
	int   n_driven = 0;

	banked_rom_mapper i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#(40_000_000);
		$display("%0t: timeout, %0d transactions still pending", $time, reply_q.size());
		$display("banked_rom_mapper regression: fail");
		$finish;
	end

	function automatic int unsigned image_bytes();
		int unsigned pages;
		pages = (image_pages_cfg > 9'(MEM_PAGES)) ? 32'(MEM_PAGES) : 32'(image_pages_cfg);
		return pages * 32'(PAGE_BYTES);
	endfunction

	function automatic rom_reply_t map_access(access_t a);
		rom_reply_t  r;
		logic        hit;
		logic        wr;
		int unsigned ofs;
		r.rdata = 8'h00;
		r.driven = 1'b0;
		hit = 1'b0;
		ofs = 0;
		wr = (a.op == OP_BUS_WRITE) || (a.op == OP_IMAGE_WRITE);
		if (a.op == OP_IMAGE_READ || a.op == OP_IMAGE_WRITE) begin
			ofs = 32'(a.img_addr);
			hit = 1'b1;
		end else if (a.cs) begin
			if (map_banked) begin
				if (a.bus_addr[15:3] == WINDOW_BASE[15:3]) begin
					if (wr) begin
						bank_shadow[a.bus_addr[2:0]] = a.wdata;
					end else begin
						r.rdata = bank_shadow[a.bus_addr[2:0]];
						r.driven = 1'b1;
					end
				end else if (a.bus_addr[15]) begin
					ofs = 32'(bank_shadow[a.bus_addr[14:12]]) * 32'(PAGE_BYTES) +
					      32'(a.bus_addr[11:0]);
					hit = 1'b1;
				end
			end else if (a.bus_addr >= flat_base) begin
				ofs = 32'(a.bus_addr - flat_base);
				hit = 1'b1;
			end
		end
		if (hit) begin
			if (ofs < image_bytes()) begin
				if (wr) begin
					image_shadow[ofs] = a.wdata;
				end else begin
					r.rdata = image_shadow.exists(ofs) ? image_shadow[ofs] : 8'hFF;
					r.driven = 1'b1;
				end
			end else if (!wr) begin
				r.rdata = 8'hFF;
				r.driven = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic logic [11:0] pick_low();
		case ($urandom_range(0, 3))
			0: begin
				return 12'($urandom_range(0, 3));
			end
			1: begin
				return 12'($urandom_range(12'hFFC, 12'hFFF));
			end
			default: begin
				return 12'($urandom_range(0, 4095));
			end
		endcase
	endfunction

	function automatic logic [7:0] pick_page();
		int k;
		k = $urandom_range(0, 9);
		if (k < 5) begin
			return 8'($urandom_range(0, 3));
		end else if (k < 7) begin
			return (image_pages_cfg == 0) ? 8'd0 :
			       8'(image_pages_cfg - 9'($urandom_range(0, 1)));
		end
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic access_t random_access();
		access_t     a;
		int          k;
		logic [15:0] span;
		k = $urandom_range(0, 99);
		if (k < 30) begin
			a.op = OP_BUS_READ;
		end else if (k < 55) begin
			a.op = OP_BUS_WRITE;
		end else if (k < 78) begin
			a.op = OP_IMAGE_READ;
		end else begin
			a.op = OP_IMAGE_WRITE;
		end
		a.cs = ($urandom_range(0, 9) != 0);
		a.wdata = 8'($urandom_range(0, 255));
		a.img_addr = ($urandom_range(0, 4) == 0) ? 20'($urandom_range(0, 20'hFFFFF))
		                                         : {pick_page(), pick_low()};
		k = $urandom_range(0, 9);
		if (k < 2) begin
			a.bus_addr = 16'(WINDOW_BASE + $urandom_range(0, 7));
			if (map_banked)
				a.wdata = pick_page();
		end else if (k < 3) begin
			a.bus_addr = 16'($urandom_range(0, 16'hFFFF));
		end else if (k < 4) begin
			a.bus_addr = 16'(flat_base + $urandom_range(0, 3) - 2);
		end else if (map_banked) begin
			a.bus_addr = {1'b1, 3'($urandom_range(0, 7)), pick_low()};
		end else begin
			span = {pick_page(), pick_low()};
			a.bus_addr = flat_base + span;
		end
		return a;
	endfunction

	task automatic push_access(opcode_t op, logic cs, logic [15:0] bus, logic [19:0] img,
	                           logic [7:0] wd);
		access_t a;
		a.op = op;
		a.cs = cs;
		a.bus_addr = bus;
		a.img_addr = img;
		a.wdata = wd;
		access_q.push_back(a);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			CFG_BANKING_ENABLE: begin
				map_banked = value[0];
			end
			CFG_LOAD_ADDRESS: begin
				flat_base = value;
			end
			CFG_IMAGE_PAGES: begin
				image_pages_cfg = value[8:0];
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (access_q.size() != 0 || s_tvalid || reply_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic run_setting(logic banked, logic [15:0] base, logic [8:0] pages, int count);
		drain();
		write_reg(CFG_BANKING_ENABLE, {15'd0, banked});
		write_reg(CFG_LOAD_ADDRESS, base);
		write_reg(CFG_IMAGE_PAGES, {7'd0, pages});
		n_settings++;
		repeat (count) access_q.push_back(random_access());
	endtask

	initial begin
		foreach (bank_shadow[i])
			bank_shadow[i] = 8'h00;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// flat mapping from 0x8000, full image
		run_setting(1'b0, 16'h8000, 9'd256, 0);
		push_access(OP_IMAGE_WRITE, 1'b1, 16'h0000, 20'h00000, 8'hA5);
		push_access(OP_IMAGE_WRITE, 1'b0, 16'hFFFF, 20'hFFFFF, 8'h5A);
		push_access(OP_IMAGE_READ,  1'b1, 16'h0000, 20'h00000, 8'h00);
		push_access(OP_IMAGE_READ,  1'b0, 16'hFFFF, 20'hFFFFF, 8'hFF);
		push_access(OP_BUS_READ,    1'b1, 16'h8000, 20'h00000, 8'h00);
		push_access(OP_BUS_READ,    1'b1, 16'h7FFF, 20'hFFFFF, 8'hFF);
		push_access(OP_BUS_READ,    1'b0, 16'h8000, 20'h00000, 8'h00);
		push_access(OP_BUS_WRITE,   1'b1, 16'hFFFF, 20'h00000, 8'h3C);
		push_access(OP_IMAGE_READ,  1'b1, 16'h0000, 20'h07FFF, 8'h00);
		push_access(OP_BUS_WRITE,   1'b0, 16'h8001, 20'h00000, 8'h77);
		push_access(OP_IMAGE_READ,  1'b1, 16'h0000, 20'h00001, 8'h00);
		repeat (RANDOM_PER_SETTING) access_q.push_back(random_access());

		// bank switching, full image
		run_setting(1'b1, 16'h8000, 9'd256, 0);
		push_access(OP_BUS_WRITE,   1'b1, WINDOW_BASE,         20'h00000, 8'hFF);
		push_access(OP_BUS_WRITE,   1'b1, WINDOW_BASE + 16'd7, 20'h00000, 8'h00);
		push_access(OP_BUS_READ,    1'b1, WINDOW_BASE,         20'h00000, 8'h00);
		push_access(OP_BUS_READ,    1'b1, WINDOW_BASE + 16'd7, 20'h00000, 8'h00);
		push_access(OP_BUS_WRITE,   1'b1, 16'h8FFF,            20'h00000, 8'h11);
		push_access(OP_IMAGE_READ,  1'b1, 16'h0000,            20'hFFFFF, 8'h00);
		push_access(OP_BUS_READ,    1'b1, 16'h7FFF,            20'h00000, 8'h00);
		push_access(OP_BUS_WRITE,   1'b0, WINDOW_BASE + 16'd3, 20'h00000, 8'h44);
		push_access(OP_BUS_READ,    1'b1, WINDOW_BASE + 16'd3, 20'h00000, 8'h00);
		push_access(OP_BUS_READ,    1'b1, 16'hF000,            20'h00000, 8'h00);
		repeat (RANDOM_PER_SETTING) access_q.push_back(random_access());

		run_setting(1'b0, 16'h0000, 9'd16,  RANDOM_PER_SETTING);
		run_setting(1'b1, 16'h8000, 9'd1,   RANDOM_PER_SETTING);
		run_setting(1'b0, 16'hFFFF, 9'd256, RANDOM_PER_SETTING);
		// empty image: every image read answers 0xFF
		run_setting(1'b1, 16'h1234, 9'd0,   RANDOM_PER_SETTING);
		run_setting(1'b0, 16'($urandom_range(0, 16'hFFFF)), 9'($urandom_range(1, 256)),
		            RANDOM_PER_SETTING);
		run_setting(1'b1, 16'($urandom_range(0, 16'hFFFF)), 9'($urandom_range(1, 256)),
		            RANDOM_PER_SETTING);

		drain();
		$display("covered %0d mapping settings: %0d bus reads, %0d bus writes, %0d image reads,",
		         n_settings, n_op[OP_BUS_READ], n_op[OP_BUS_WRITE], n_op[OP_IMAGE_READ]);
		$display("  %0d image writes, %0d driven replies, %0d mismatches",
		         n_op[OP_IMAGE_WRITE], n_driven, errors);
		if (errors == 0) begin
			$display("banked_rom_mapper regression: pass");
		end else begin
			$display("banked_rom_mapper regression: fail");
		end
		$finish;
	end

	// sender: bursts of transactions separated by random gaps
	always @(negedge clk) begin
		if (!(s_tvalid && !took)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (access_q.size() != 0) begin
				cur_access = access_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= cur_access.op;
				s_tdata <= {3'b000, cur_access.wdata, cur_access.img_addr,
				            cur_access.bus_addr, cur_access.cs};
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern is picked anew at random whenever stall_cnt runs out
	always @(negedge clk) begin
		if (stall_cnt == 0) begin
			stall_cnt = 50;
			stall_mode = $urandom_range(0, 3);
		end
		stall_cnt--;
		case (stall_mode)
			0: begin
				m_tready <= 1'b1;
			end
			1: begin
				m_tready <= 1'($urandom_range(0, 1));
			end
			2: begin
				m_tready <= (stall_cnt % 5) >= 2;
			end
			default: begin
				m_tready <= ($urandom_range(0, 9) == 0);
			end
		endcase
	end

	always @(posedge clk) begin
		rom_reply_t want;
		took <= s_tvalid && s_tready;
		if (arst_n && m_tvalid && m_tready) begin
			if (reply_q.size() == 0) begin
				$display("%0t: unexpected transaction, read_data %02h data_driven %0b",
				         $time, m_tdata, m_tuser);
				errors++;
			end else begin
				want = reply_q.pop_front();
				if (m_tdata !== want.rdata) begin
					$display("%0t: read_data expected %02h actual %02h",
					         $time, want.rdata, m_tdata);
					errors++;
				end
				if (m_tuser[0] !== want.driven) begin
					$display("%0t: data_driven expected %0b actual %0b",
					         $time, want.driven, m_tuser[0]);
					errors++;
				end
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			want = map_access(cur_access);
			reply_q.push_back(want);
			n_op[cur_access.op]++;
			if (want.driven)
				n_driven++;
		end
	end

endmodule

// File: banked_rom_mapper.f
+incdir+src
src/brm_pkg.sv
src/brm_ram.sv
src/brm_datapath.sv
src/brm_ctrl.sv
src/banked_rom_mapper.sv
dv/tb_banked_rom_mapper.sv
